FILE: rtl/sorted_list_table_defines.svh
// assertion macros for the sorted list table top level
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLT_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/slt_pkg.sv
// types and constants shared by the sorted list table modules
`timescale 1ns / 1ps

package slt_pkg;

  localparam int VAL_W    = 32;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic ins;
    logic del;
    logic dump_empty;
    logic dump_start;
    logic dump_emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic dump_last;
  } sts_t;

endpackage

FILE: rtl/sorted_list_table.sv
// sorted list table top level: controller plus entry datapath
//
// keeps up to CAPACITY signed 32-bit entries in ascending order.
// a request is taken on a rising edge with start_i high and busy_o low:
// opcode_i selects insert, delete or dump, operand_value_i the value.
// every result is shown for one cycle with result_valid_o high; last_o
// marks the final result of a request. the receiver cannot stall.
// insert and delete compare every cell at once and shift the chain in
// the cycle the request is taken; their single result follows in the next
// cycle and busy_o stays low, so one request per cycle is accepted.
// a dump raises busy_o while a read counter walks the chain one entry
// per cycle; results follow in the next cycle, the last one in the
// cycle busy_o drops. a dump of an empty table gives one empty-status
// result in the next cycle. reserved opcode three does nothing. reset
// empties the table and clears busy_o and the strobe.
`timescale 1ns / 1ps
`include "sorted_list_table_defines.svh"

module sorted_list_table import slt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic        [OPCODE_W-1:0] opcode_i,
  input  logic signed [VAL_W-1:0]    operand_value_i,
  output logic                       result_valid_o,
  output logic signed [VAL_W-1:0]    entry_value_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [COUNT_W-1:0]  entry_count_o,
  output logic                       last_o
);

  cmd_t cmd;
  sts_t sts;

  slt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operand_value_i (operand_value_i),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .entry_value_o   (entry_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o)
  );

  `SLT_ASSERT(a_single_result, clk_i, rst_ni, start_i && !busy_o && (opcode_i == OP_INSERT || opcode_i == OP_DELETE) |=> result_valid_o && last_o, "insert or delete without a single final result")
  `SLT_ASSERT(a_dump_busy, clk_i, rst_ni, result_valid_o && !last_o |-> busy_o, "non-final dump result while idle")
  `SLT_ASSERT(a_dump_end, clk_i, rst_ni, $fell(busy_o) |-> result_valid_o && last_o, "dump ended without a final result")
  `SLT_ASSERT_NORST(a_reset_quiet, clk_i, !rst_ni |-> !busy_o && !result_valid_o, "activity during reset")

endmodule

FILE: rtl/slt_ctrl.sv
// controller state machine for the sorted list table
`timescale 1ns / 1ps

module slt_ctrl import slt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  sts_t                sts_i,
  output cmd_t                cmd_o,
  output logic                busy_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = busy_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_INSERT: cmd_o.ins = 1'b1;
            OP_DELETE: cmd_o.del = 1'b1;
            OP_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.dump_empty = 1'b1;
              end else begin
                cmd_o.dump_start = 1'b1;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      S_DUMP: cmd_o.dump_emit = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.dump_start) begin
            state_q <= S_DUMP;
            busy_q  <= 1'b1;
          end
        end
        S_DUMP: begin
          if (sts_i.dump_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/slt_datapath.sv
// entry cell chain, dump read counter and result register
`timescale 1ns / 1ps

module slt_datapath import slt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic signed [VAL_W-1:0]    operand_value_i,
  output sts_t                       sts_o,
  output logic                       result_valid_o,
  output logic signed [VAL_W-1:0]    entry_value_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [COUNT_W-1:0]  entry_count_o,
  output logic                       last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [VAL_W-1:0] entries_q [CAPACITY];
  logic signed [VAL_W-1:0] ins_d     [CAPACITY];
  logic signed [VAL_W-1:0] del_d     [CAPACITY];
  logic [CW-1:0]           count_q, count_d;
  logic [IW-1:0]           idx_q;
  logic [CAPACITY-1:0]     lt_v, eq_v;
  logic                    full, found, wr_ins, wr_del;

  logic                    res_valid_q, res_valid_d;
  logic signed [VAL_W-1:0] res_val_q, res_val_d;
  logic [STATUS_W-1:0]     res_st_q, res_st_d;
  logic [CW-1:0]           res_cnt_q, res_cnt_d;
  logic                    res_last_q, res_last_d;
  logic [CW+COUNT_W-1:0]   cnt_ext;

  // per-cell compare against the operand; sorted order makes lt_v a thermometer
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_v[i] = (CW'(i) < count_q) && (entries_q[i] < operand_value_i);
      eq_v[i] = (CW'(i) < count_q) && (entries_q[i] == operand_value_i);
    end
  end

  assign full  = (count_q == CW'(CAPACITY));
  assign found = |eq_v;

  // insert opens a gap at the first cell not below the operand
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_v[i]) begin
        ins_d[i] = entries_q[i];
      end else if (i == 0) begin
        ins_d[i] = operand_value_i;
      end else if (lt_v[i-1]) begin
        ins_d[i] = operand_value_i;
      end else begin
        ins_d[i] = entries_q[i-1];
      end
    end
  end

  // delete closes the gap at the first cell equal to the operand
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_v[i] || i == CAPACITY - 1) begin
        del_d[i] = entries_q[i];
      end else begin
        del_d[i] = entries_q[i+1];
      end
    end
  end

  assign wr_ins = cmd_i.ins && !full;
  assign wr_del = cmd_i.del && (count_q != '0) && found;

  always_comb begin
    priority if (wr_ins) begin
      count_d = count_q + CW'(1);
    end else if (wr_del) begin
      count_d = count_q - CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.dump_last = (CW'(idx_q) == count_q - CW'(1));

  // result selection
  always_comb begin
    res_valid_d = cmd_i.ins || cmd_i.del || cmd_i.dump_empty || cmd_i.dump_emit;
    res_val_d   = operand_value_i;
    res_st_d    = ST_OK;
    res_cnt_d   = count_d;
    res_last_d  = 1'b1;
    priority if (cmd_i.ins) begin
      res_st_d = full ? ST_FULL : ST_OK;
    end else if (cmd_i.del) begin
      priority if (count_q == '0) begin
        res_st_d = ST_EMPTY;
      end else if (!found) begin
        res_st_d = ST_NOTFOUND;
      end else begin
        res_st_d = ST_OK;
      end
    end else if (cmd_i.dump_empty) begin
      res_val_d = '0;
      res_st_d  = ST_EMPTY;
    end else if (cmd_i.dump_emit) begin
      res_val_d  = entries_q[idx_q];
      res_last_d = sts_o.dump_last;
    end else begin
      res_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cmd_i.dump_start) begin
        idx_q <= '0;
      end else if (cmd_i.dump_emit) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ins) begin
      entries_q <= ins_d;
    end else if (wr_del) begin
      entries_q <= del_d;
    end
    if (res_valid_d) begin
      res_val_q  <= res_val_d;
      res_st_q   <= res_st_d;
      res_cnt_q  <= res_cnt_d;
      res_last_q <= res_last_d;
    end
  end

  assign cnt_ext        = {{COUNT_W{1'b0}}, res_cnt_q};
  assign result_valid_o = res_valid_q;
  assign entry_value_o  = res_val_q;
  assign status_o       = res_st_q;
  assign entry_count_o  = cnt_ext[COUNT_W-1:0];
  assign last_o         = res_last_q;

endmodule

FILE: tb/sv/tb_sorted_list_table.sv
// testbench for the sorted list table: directed table plus random phases checked by a predictor
`timescale 1ns / 1ps

module tb_sorted_list_table import slt_pkg::*; ();

  localparam int CAPACITY     = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]     op;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    result_t                 exp;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic        [OPCODE_W-1:0] opcode_i;
  logic signed [VAL_W-1:0]    operand_value_i;
  logic                       result_valid_o;
  logic signed [VAL_W-1:0]    entry_value_o;
  logic        [STATUS_W-1:0] status_o;
  logic        [COUNT_W-1:0]  entry_count_o;
  logic                       last_o;

  sorted_list_table #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .result_valid_o  (result_valid_o),
    .entry_value_o   (entry_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic signed [VAL_W-1:0] model_entries [CAPACITY];
  int                      model_count;
  result_t                 step_results [$];
  result_t                 expected_results [$];

  // typed-in expectation for the request currently driven
  logic    typed_pending;
  result_t typed_result;

  int error_count;
  int mismatch_count;
  int cycle_count;

  function automatic result_t make_result(logic signed [VAL_W-1:0] value,
                                          logic [STATUS_W-1:0] status,
                                          int count, logic last);
    result_t r;
    r.value  = value;
    r.status = status;
    r.count  = count[COUNT_W-1:0];
    r.last   = last;
    return r;
  endfunction

  task automatic predict_request(input logic [OPCODE_W-1:0] op,
                                 input logic signed [VAL_W-1:0] val);
    int pos;
    int i;
    step_results.delete();
    case (op)
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          step_results.push_back(make_result(val, ST_FULL, model_count, 1'b1));
        end else begin
          pos = 0;
          while (pos < model_count && model_entries[pos] < val) pos++;
          for (i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
          model_entries[pos] = val;
          model_count++;
          step_results.push_back(make_result(val, ST_OK, model_count, 1'b1));
        end
      end
      OP_DELETE: begin
        if (model_count == 0) begin
          step_results.push_back(make_result(val, ST_EMPTY, 0, 1'b1));
        end else begin
          pos = 0;
          while (pos < model_count && model_entries[pos] != val) pos++;
          if (pos >= model_count) begin
            step_results.push_back(make_result(val, ST_NOTFOUND, model_count, 1'b1));
          end else begin
            for (i = pos; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
            model_count--;
            step_results.push_back(make_result(val, ST_OK, model_count, 1'b1));
          end
        end
      end
      OP_DUMP: begin
        if (model_count == 0) begin
          step_results.push_back(make_result('0, ST_EMPTY, 0, 1'b1));
        end else begin
          for (i = 0; i < model_count; i++)
            step_results.push_back(make_result(model_entries[i], ST_OK, model_count,
                                               (i + 1 == model_count)));
        end
      end
      default: ;  // reserved opcode does nothing
    endcase
  endtask

  // request capture and result checking, both on the rising edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_request(opcode_i, operand_value_i);
        if (typed_pending) expected_results.push_back(typed_result);
        else foreach (step_results[k]) expected_results.push_back(step_results[k]);
      end
      if (result_valid_o) begin
        got = make_result(entry_value_o, status_o, int'(entry_count_o), last_o);
        if (expected_results.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: value %0d status %0d count %0d last %0d",
                     got.value, got.status, got.count, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected value %0d status %0d count %0d last %0d,",
                       want.value, want.status, want.count, want.last,
                       " got value %0d status %0d count %0d last %0d",
                       got.value, got.status, got.count, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(bit no_idle);
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4, 5: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // start stays high across back-to-back requests; this task lowers it only for a gap
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic signed [VAL_W-1:0] val,
                              input int gap, input logic typed, input result_t exp);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i         = 1'b1;
    opcode_i        = op;
    operand_value_i = val;
    typed_pending   = typed;
    typed_result    = exp;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    start_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic stim_row_t row(logic [OPCODE_W-1:0] op, logic signed [VAL_W-1:0] val,
                                    logic typed, result_t exp);
    stim_row_t r;
    r.op    = op;
    r.value = val;
    r.typed = typed;
    r.exp   = exp;
    return r;
  endfunction

  stim_row_t directed_rows [$];

  initial begin
    int   roll;
    int   mode;
    bit   no_idle;
    logic [OPCODE_W-1:0] op;
    logic signed [VAL_W-1:0] val;
    result_t none;

    none            = '0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    opcode_i        = '0;
    operand_value_i = '0;
    typed_pending   = 1'b0;
    typed_result    = '0;
    error_count     = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    model_count     = 0;
    foreach (model_entries[k]) model_entries[k] = '0;

    directed_rows.push_back(row(OP_DUMP, 32'sd77, 1'b1, make_result('0, ST_EMPTY, 0, 1'b1)));
    directed_rows.push_back(row(OP_DELETE, 32'sd5, 1'b1, make_result(5, ST_EMPTY, 0, 1'b1)));
    directed_rows.push_back(row(OP_RESERVED, 32'sd9, 1'b0, none));
    directed_rows.push_back(row(OP_INSERT, 32'sh7fffffff, 1'b1,
                                make_result(32'sh7fffffff, ST_OK, 1, 1'b1)));
    directed_rows.push_back(row(OP_INSERT, 32'sh80000000, 1'b1,
                                make_result(32'sh80000000, ST_OK, 2, 1'b1)));
    directed_rows.push_back(row(OP_INSERT, 32'sd0, 1'b0, none));
    // equal value goes in front of the existing copy
    directed_rows.push_back(row(OP_INSERT, 32'sd0, 1'b0, none));
    directed_rows.push_back(row(OP_INSERT, -32'sd1, 1'b0, none));
    directed_rows.push_back(row(OP_INSERT, 32'sd1, 1'b0, none));
    directed_rows.push_back(row(OP_DELETE, 32'sd12345, 1'b1,
                                make_result(12345, ST_NOTFOUND, 6, 1'b1)));
    directed_rows.push_back(row(OP_DUMP, 32'sd0, 1'b0, none));
    directed_rows.push_back(row(OP_DELETE, 32'sd0, 1'b0, none));
    directed_rows.push_back(row(OP_DELETE, 32'sh80000000, 1'b0, none));
    directed_rows.push_back(row(OP_DELETE, 32'sh7fffffff, 1'b0, none));
    directed_rows.push_back(row(OP_RESERVED, -32'sd1, 1'b0, none));
    directed_rows.push_back(row(OP_DUMP, 32'sd0, 1'b0, none));
    directed_rows.push_back(row(OP_INSERT, 32'sh55555555, 1'b0, none));
    directed_rows.push_back(row(OP_INSERT, 32'shaaaaaaaa, 1'b0, none));
    directed_rows.push_back(row(OP_DUMP, 32'sd0, 1'b0, none));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k])
      send_request(directed_rows[k].op, directed_rows[k].value, pick_gap(k < 8),
                   directed_rows[k].typed, directed_rows[k].exp);

    // sender holds off until every result is back
    wait_for_results();

    // random phases: fill, drain, mixed and dump-heavy, so the table goes full and empty
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      mode    = phase % 4;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; ) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       op = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                        (roll < 96) ? OP_DUMP : OP_RESERVED;
          1:       op = (roll < 15) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                        (roll < 96) ? OP_DUMP : OP_RESERVED;
          2:       op = (roll < 45) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                        (roll < 96) ? OP_DUMP : OP_RESERVED;
          default: op = (roll < 35) ? OP_INSERT : (roll < 60) ? OP_DELETE :
                        (roll < 96) ? OP_DUMP : OP_RESERVED;
        endcase
        // deletes mostly hit a stored value
        if (op == OP_DELETE && model_count > 0 && $urandom_range(0, 9) < 6)
          val = model_entries[$urandom_range(0, model_count - 1)];
        else
          val = pick_value();
        send_request(op, val, pick_gap(no_idle), 1'b0, none);
        if (op != OP_RESERVED) begin
          n++;
        end
      end
      if (phase % 2 == 1) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_datapath.sv
rtl/sorted_list_table.sv
tb/sv/tb_sorted_list_table.sv
